@@ rtl/tpbb_pkg.sv @@
`default_nettype none
package tpbb_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int COEF_W      = 16;
  localparam int CFG_W       = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_W       = 24;
  localparam int HALF_W      = 23;
  localparam int NUM_AXES    = 3;
  localparam int FRAC_SHIFT  = 14;
  localparam int PROD_W      = COORD_WIDTH + COEF_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int ACC_W       = SUM_W + 1;
  localparam int QDEPTH      = 8;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [CFG_W-1:0] ROW_X_RST = 48'h0000_0000_4000;
  localparam logic [CFG_W-1:0] ROW_Y_RST = 48'h0000_4000_0000;
  localparam logic [CFG_W-1:0] ROW_Z_RST = 48'h4000_0000_0000;
  localparam logic [CFG_W-1:0] TRANS_RST = 48'h0000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X = 3'd0,
    REG_ROW_Y = 3'd1,
    REG_ROW_Z = 3'd2,
    REG_TRANS = 3'd3
  } cfg_idx_e;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [OUT_W-1:0]       box_t;
  typedef logic [HALF_W-1:0]             half_t;
  typedef logic [CFG_W-1:0]              cfg_word_t;

  typedef struct packed {
    cfg_word_t row_x;
    cfg_word_t row_y;
    cfg_word_t row_z;
    cfg_word_t trans;
  } cfg_t;

  typedef struct packed {
    logic                        last;
    logic [NUM_AXES-1:0][OUT_W-1:0] p;
  } point_t;

  function automatic logic signed [COEF_W-1:0] lane(cfg_word_t w, int k);
    return $signed(w[k*COEF_W +: COEF_W]);
  endfunction

endpackage
`default_nettype wire

@@ rtl/tpbb_vtx_if.sv @@
`default_nettype none
interface tpbb_vtx_if;
  import tpbb_pkg::*;

  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  coord_t vertex_z;
  logic   last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface
`default_nettype wire

@@ rtl/tpbb_box_if.sv @@
`default_nettype none
interface tpbb_box_if;
  import tpbb_pkg::*;

  logic  valid;
  logic  ready;
  box_t  box_min_x;
  box_t  box_min_y;
  box_t  box_min_z;
  box_t  box_max_x;
  box_t  box_max_y;
  box_t  box_max_z;
  half_t half_diag_x;
  half_t half_diag_y;
  half_t half_diag_z;
  box_t  center_x;
  box_t  center_y;
  box_t  center_z;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           half_diag_x, half_diag_y, half_diag_z, center_x, center_y, center_z,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           half_diag_x, half_diag_y, half_diag_z, center_x, center_y, center_z,
    output ready
  );
endinterface
`default_nettype wire

@@ rtl/tpbb_xform.sv @@
`default_nettype none
module tpbb_xform (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  tpbb_vtx_if.sink                           vtx_i,
  input  wire tpbb_pkg::cfg_t                cfg_i,
  input  wire logic [tpbb_pkg::QCNT_W-1:0]   level_i,
  output logic                               push_o,
  output tpbb_pkg::point_t                   point_o
);
  import tpbb_pkg::*;

  logic                     v1_q, v2_q;
  logic                     last1_q;
  logic signed [PROD_W-1:0] prod_q [NUM_AXES][NUM_AXES];
  logic signed [PROD_W-1:0] prod_d [NUM_AXES][NUM_AXES];
  point_t                   pt2_q, pt2_d;
  logic [QCNT_W:0]          inflight;
  logic                     accept;

  function automatic logic [OUT_W-1:0] sat_out(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = $signed({{(ACC_W-OUT_W){1'b0}}, 1'b0, {(OUT_W-1){1'b1}}});
    lo = $signed({{(ACC_W-OUT_W){1'b1}}, 1'b1, {(OUT_W-1){1'b0}}});
    if (v > hi) begin
      return hi[OUT_W-1:0];
    end else if (v < lo) begin
      return lo[OUT_W-1:0];
    end
    return v[OUT_W-1:0];
  endfunction

  assign inflight = {1'b0, level_i} + (QCNT_W+1)'(v1_q) + (QCNT_W+1)'(v2_q);
  assign vtx_i.ready = inflight < (QCNT_W+1)'(QDEPTH);
  assign accept = vtx_i.valid && vtx_i.ready;

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      prod_d[k][0] = vtx_i.vertex_x * lane(cfg_i.row_x, k);
      prod_d[k][1] = vtx_i.vertex_y * lane(cfg_i.row_y, k);
      prod_d[k][2] = vtx_i.vertex_z * lane(cfg_i.row_z, k);
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] shr;
    logic signed [ACC_W-1:0] acc;
    pt2_d.last = last1_q;
    pt2_d.p    = '0;
    for (int k = 0; k < NUM_AXES; k++) begin
      sum = SUM_W'(prod_q[k][0]) + SUM_W'(prod_q[k][1]) + SUM_W'(prod_q[k][2]);
      shr = sum >>> FRAC_SHIFT;
      acc = ACC_W'(shr) + ACC_W'(lane(cfg_i.trans, k));
      pt2_d.p[k] = sat_out(acc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      prod_q  <= prod_d;
      last1_q <= vtx_i.last_vertex;
    end
    if (v1_q) begin
      pt2_q <= pt2_d;
    end
  end

  assign push_o  = v2_q;
  assign point_o = pt2_q;

endmodule
`default_nettype wire

@@ rtl/tpbb_fifo.sv @@
`default_nettype none
module tpbb_fifo (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire tpbb_pkg::point_t            point_i,
  input  wire logic                        pop_i,
  output logic                             valid_o,
  output tpbb_pkg::point_t                 point_o,
  output logic [tpbb_pkg::QCNT_W-1:0]      level_o
);
  import tpbb_pkg::*;

  point_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= point_i;
    end
  end

  assign valid_o = cnt_q != '0;
  assign point_o = mem_q[rd_q];
  assign level_o = cnt_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue level beyond depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> cnt_q != QCNT_W'(QDEPTH))
    else $error("push into full queue");
`endif

endmodule
`default_nettype wire

@@ rtl/tpbb_accum.sv @@
`default_nettype none
module tpbb_accum (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire tpbb_pkg::point_t  point_i,
  output logic                   pop_o,
  tpbb_box_if.source             box_o
);
  import tpbb_pkg::*;

  box_t  min_q [NUM_AXES];
  box_t  max_q [NUM_AXES];
  box_t  min_d [NUM_AXES];
  box_t  max_d [NUM_AXES];
  logic  first_q;
  logic  a_valid_q;
  box_t  a_min_q [NUM_AXES];
  box_t  a_max_q [NUM_AXES];
  logic  b_valid_q;
  box_t  b_min_q [NUM_AXES];
  box_t  b_max_q [NUM_AXES];
  half_t b_half_q [NUM_AXES];
  box_t  b_ctr_q [NUM_AXES];
  half_t half_d [NUM_AXES];
  box_t  ctr_d [NUM_AXES];
  logic  a_ready, b_ready;

  assign b_ready = !b_valid_q || box_o.ready;
  assign a_ready = !a_valid_q || b_ready;
  assign pop_o   = valid_i && (!point_i.last || a_ready);

  always_comb begin
    box_t p;
    for (int k = 0; k < NUM_AXES; k++) begin
      p = $signed(point_i.p[k]);
      min_d[k] = (first_q || p < min_q[k]) ? p : min_q[k];
      max_d[k] = (first_q || p > max_q[k]) ? p : max_q[k];
    end
  end

  always_comb begin
    logic [OUT_W-1:0] diff;
    for (int k = 0; k < NUM_AXES; k++) begin
      diff      = a_max_q[k] - a_min_q[k];
      half_d[k] = diff[OUT_W-1:1];
      ctr_d[k]  = a_min_q[k] + $signed({1'b0, half_d[k]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q   <= 1'b1;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      for (int k = 0; k < NUM_AXES; k++) begin
        min_q[k] <= '0;
        max_q[k] <= '0;
      end
    end else begin
      if (pop_o) begin
        first_q <= point_i.last;
        min_q   <= min_d;
        max_q   <= max_d;
      end
      if (pop_o && point_i.last) begin
        a_valid_q <= 1'b1;
      end else if (b_ready) begin
        a_valid_q <= 1'b0;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && point_i.last) begin
      a_min_q <= min_d;
      a_max_q <= max_d;
    end
    if (b_ready && a_valid_q) begin
      b_min_q  <= a_min_q;
      b_max_q  <= a_max_q;
      b_half_q <= half_d;
      b_ctr_q  <= ctr_d;
    end
  end

  assign box_o.valid       = b_valid_q;
  assign box_o.box_min_x   = b_min_q[0];
  assign box_o.box_min_y   = b_min_q[1];
  assign box_o.box_min_z   = b_min_q[2];
  assign box_o.box_max_x   = b_max_q[0];
  assign box_o.box_max_y   = b_max_q[1];
  assign box_o.box_max_z   = b_max_q[2];
  assign box_o.half_diag_x = b_half_q[0];
  assign box_o.half_diag_y = b_half_q[1];
  assign box_o.half_diag_z = b_half_q[2];
  assign box_o.center_x    = b_ctr_q[0];
  assign box_o.center_y    = b_ctr_q[1];
  assign box_o.center_z    = b_ctr_q[2];

`ifndef SYNTHESIS
  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> b_min_q[0] <= b_max_q[0] && b_min_q[1] <= b_max_q[1]
                  && b_min_q[2] <= b_max_q[2])
    else $error("box min above max");
  a_center_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> b_ctr_q[0] >= b_min_q[0] && b_ctr_q[0] <= b_max_q[0])
    else $error("center outside box");
  a_last_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && point_i.last |=> first_q && a_valid_q)
    else $error("last transfer did not close the set");
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !b_ready |=> a_valid_q && $stable(a_min_q[0]) && $stable(a_max_q[0]))
    else $error("pending box lost under stall");
`endif

endmodule
`default_nettype wire

@@ rtl/transformed_point_bounding_box.sv @@
// Channel   Dir  Modport  Transfer when         Payload
// vtx_i     in   sink     valid && ready        vertex_x/y/z, last_vertex
// box_o     out  source   valid && ready        box_min/max, half_diag, center
// cfg       in   -        cfg_we_i              cfg_idx_i, cfg_data_i
//
// One vertex per cycle while vtx_i.ready is high; nine 16x16 multipliers and a
// three-input add give a two-stage transform ahead of an 8-entry queue.
// The min/max update loops through its own registers. Box valid rises after the
// last vertex passes the transform stages, the queue and two result registers.
// vtx_i.ready drops only when the queue plus in-flight vertices reach 8.
// Reset is asynchronous active low; no clearing pass.
`default_nettype none
module transformed_point_bounding_box (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  tpbb_vtx_if.sink                             vtx_i,
  tpbb_box_if.source                           box_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [tpbb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tpbb_pkg::CFG_W-1:0]      cfg_data_i
);
  import tpbb_pkg::*;

  cfg_t              cfg_q;
  logic              push;
  point_t            push_pt;
  logic              q_valid;
  point_t            q_pt;
  logic              pop;
  logic [QCNT_W-1:0] level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_x <= ROW_X_RST;
      cfg_q.row_y <= ROW_Y_RST;
      cfg_q.row_z <= ROW_Z_RST;
      cfg_q.trans <= TRANS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_ROW_X: cfg_q.row_x <= cfg_data_i;
        REG_ROW_Y: cfg_q.row_y <= cfg_data_i;
        REG_ROW_Z: cfg_q.row_z <= cfg_data_i;
        REG_TRANS: cfg_q.trans <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tpbb_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vtx_i   (vtx_i),
    .cfg_i   (cfg_q),
    .level_i (level),
    .push_o  (push),
    .point_o (push_pt)
  );

  tpbb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .point_i (push_pt),
    .pop_i   (pop),
    .valid_o (q_valid),
    .point_o (q_pt),
    .level_o (level)
  );

  tpbb_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .point_i (q_pt),
    .pop_o   (pop),
    .box_o   (box_o)
  );

endmodule
`default_nettype wire
